FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the compensation RTL
// Every check is clocked on i_clk and switched off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge
`define BSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Check that a condition never occurs
`define BSC_NEVER(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error(msg);

`endif

FILE: hw/rtl/bsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsc_pkg
// Types, constants and partial-product helpers for the barometric sensor
// compensation pipeline.
// ----------------------------------------------------------------------------
package bsc_pkg;

    // Long divider: one quotient bit per stage, divisor magnitude width
    localparam int QUO_W      = 64;
    localparam int DIV_STAGES = QUO_W;
    localparam int DV_W       = 31;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_TEMP_COEF   = 3'd0,
        CFG_PRESS_LO    = 3'd1,
        CFG_PRESS_HI    = 3'd2,
        CFG_PRESS_NINE  = 3'd3,
        CFG_PRESS_OFFSET = 3'd4
    } t_cfg_index;

    // Side data carried alongside the divider
    typedef struct packed {
        logic [15:0] temp;
        logic        dz;
        logic        neg;
    } t_div_side;

    // Two partial products of a 64-bit word times a signed 17-bit factor
    typedef struct packed {
        logic signed [49:0] lo;
        logic [31:0]        hi;
    } t_part;

    // Form the partial products; low half exact, high half kept mod 2^32
    function automatic t_part mul_part(input logic [63:0] a,
                                       input logic signed [16:0] b);
        t_part              res;
        logic signed [48:0] full_hi;
        res.lo  = 50'($signed({1'b0, a[31:0]})) * 50'(b);
        full_hi = 49'($signed({1'b0, a[63:32]})) * 49'(b);
        res.hi  = full_hi[31:0];
        return res;
    endfunction

    // Combine partial products into the product modulo 2^64
    function automatic logic [63:0] part_sum(input t_part p);
        return {{14{p.lo[49]}}, p.lo} + {p.hi, 32'd0};
    endfunction

endpackage

FILE: hw/rtl/baro_sensor_compensation.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// baro_sensor_compensation
// Integer temperature and pressure compensation of a barometric sensor.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (i_s_*) takes one transaction per raw sample pair:
//   temperature in tdata[19:0], pressure in tdata[39:20].
//   Master channel (o_m_*) gives one transaction per sample pair:
//   temperature in 0.01 degree in tdata[15:0], pressure code in
//   tdata[31:16], divide-by-zero flag in tuser.
//   Factory coefficients and the pressure offset are loaded through the
//   write port (i_cfg_*) while no transaction is in flight.
//   Accept to result: 13 arithmetic stages, 64 divider stages (one quotient
//   bit each), 7 stages of second-order terms and the output register.
//   One pair is accepted every cycle while no result waits on a stalled receiver.
//   Reset clears the coefficients and all valid bits; the pipeline is
//   empty after reset.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and o_s_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module baro_sensor_compensation
    import bsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_wr_en,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_wdata,
    // slave channel
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // raw_temperature[19:0], raw_pressure[39:20]
    // master channel
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // temperature_centi[15:0], pressure_code[31:16]
    output logic        o_m_tuser    // divide_by_zero[0]
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [47:0] r_temp_coef;
    logic [63:0] r_press_lo;
    logic [63:0] r_press_hi;
    logic [15:0] r_press_nine;
    logic [16:0] r_press_offset;

    // Write a register; ignore indexes beyond the list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_coef    <= '0;
            r_press_lo     <= '0;
            r_press_hi     <= '0;
            r_press_nine   <= '0;
            r_press_offset <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_TEMP_COEF:    r_temp_coef    <= i_cfg_wdata[47:0];
                CFG_PRESS_LO:     r_press_lo     <= i_cfg_wdata;
                CFG_PRESS_HI:     r_press_hi     <= i_cfg_wdata;
                CFG_PRESS_NINE:   r_press_nine   <= i_cfg_wdata[15:0];
                CFG_PRESS_OFFSET: r_press_offset <= i_cfg_wdata[16:0];
                default: begin
                end
            endcase
        end
    end

    // Coefficient fields
    logic [15:0]        w_t1, w_p1;
    logic signed [15:0] w_t2, w_t3;
    logic signed [15:0] w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;

    assign w_t1 = r_temp_coef[15:0];
    assign w_t2 = $signed(r_temp_coef[31:16]);
    assign w_t3 = $signed(r_temp_coef[47:32]);
    assign w_p1 = r_press_lo[15:0];
    assign w_p2 = $signed(r_press_lo[31:16]);
    assign w_p3 = $signed(r_press_lo[47:32]);
    assign w_p4 = $signed(r_press_lo[63:48]);
    assign w_p5 = $signed(r_press_hi[15:0]);
    assign w_p6 = $signed(r_press_hi[31:16]);
    assign w_p7 = $signed(r_press_hi[47:32]);
    assign w_p8 = $signed(r_press_hi[63:48]);
    assign w_p9 = $signed(r_press_nine);

    // ------------------------------------------------------------------
    // Flow control: the whole pipeline moves unless a result is stuck
    // ------------------------------------------------------------------
    logic [12:0] r_vf;   // stages 1..13 before the divider
    logic [6:0]  r_vb;   // stages A..G after the divider
    logic        r_out_vld;

    logic w_en;
    assign w_en       = !r_out_vld || i_m_tready;
    assign o_s_tready = w_en;

    // ------------------------------------------------------------------
    // Front stages: temperature and divider operands
    // ------------------------------------------------------------------
    logic signed [17:0] r1_a;
    logic signed [16:0] r1_d;
    logic signed [33:0] r2_v1raw, r2_dd;
    logic signed [22:0] r3_v1;
    logic signed [37:0] r3_m;
    logic signed [24:0] r4_fine;
    logic signed [25:0] r5_x1;
    logic signed [51:0] r6_x1sq;
    logic signed [41:0] r6_x1p5, r6_x1p2, r7_x1p5, r7_x1p2, r8_x1p5, r8_x1p2;
    t_part              r7_q6, r7_q3, r11_qw, r11_qd;
    logic [63:0]        r8_m6, r8_m3, r9_x2, r9_x1b, r10_w, r10_dvd0;
    logic [63:0]        r12_prod, r12_dvd, r13_num;
    logic [DV_W-1:0]    r13_dv;
    t_div_side          r13_side;
    logic [15:0]        r_tout_d [8];   // stages 5..12
    logic [19:0]        r_adcp_d [9];   // stages 1..9

    logic [19:0]        w_adc_t;
    logic signed [27:0] w_f5;
    logic signed [19:0] w_tc;
    logic [15:0]        w_tout;
    logic [20:0]        w_pp;
    logic signed [DV_W-1:0] w_div;

    assign w_adc_t = i_s_tdata[19:0];
    assign w_f5    = (28'(r4_fine) <<< 2) + 28'(r4_fine) + 28'sd128;
    assign w_tc    = 20'(w_f5 >>> 8);
    assign w_pp    = 21'h100000 - {1'b0, r_adcp_d[8]};
    assign w_div   = DV_W'($signed(r12_prod) >>> 33);

    // Saturate the temperature to 16 bits
    always_comb begin
        if (w_tc > 20'sd32767) begin
            w_tout = 16'h7FFF;
        end else if (w_tc < -20'sd32768) begin
            w_tout = 16'h8000;
        end else begin
            w_tout = w_tc[15:0];
        end
    end

    // Advance the front payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // stage 1: offsets from T1
            r1_a <= $signed(18'({1'b0, w_adc_t[19:3]} - {1'b0, w_t1, 1'b0}));
            r1_d <= $signed(17'({1'b0, w_adc_t[19:4]} - {1'b0, w_t1}));
            r_adcp_d[0] <= i_s_tdata[39:20];
            for (int k = 1; k < 9; k++) begin
                r_adcp_d[k] <= r_adcp_d[k-1];
            end
            // stage 2: first-order and square terms
            r2_v1raw <= 34'(r1_a) * 34'(w_t2);
            r2_dd    <= 34'(r1_d) * 34'(r1_d);
            // stage 3
            r3_v1 <= 23'(r2_v1raw >>> 11);
            r3_m  <= 38'(r2_dd >>> 12) * 38'(w_t3);
            // stage 4: fine temperature
            r4_fine <= 25'(r3_v1) + 25'(r3_m >>> 14);
            // stage 5: temperature output, pressure offset term
            r_tout_d[0] <= w_tout;
            for (int k = 1; k < 8; k++) begin
                r_tout_d[k] <= r_tout_d[k-1];
            end
            r5_x1 <= 26'(r4_fine) - 26'sd128000;
            // stage 6
            r6_x1sq <= 52'(r5_x1) * 52'(r5_x1);
            r6_x1p5 <= 42'(r5_x1) * 42'(w_p5);
            r6_x1p2 <= 42'(r5_x1) * 42'(w_p2);
            // stage 7: partial products with P6 and P3
            r7_q6   <= mul_part(64'(r6_x1sq), 17'(w_p6));
            r7_q3   <= mul_part(64'(r6_x1sq), 17'(w_p3));
            r7_x1p5 <= r6_x1p5;
            r7_x1p2 <= r6_x1p2;
            // stage 8
            r8_m6   <= part_sum(r7_q6);
            r8_m3   <= part_sum(r7_q3);
            r8_x1p5 <= r7_x1p5;
            r8_x1p2 <= r7_x1p2;
            // stage 9
            r9_x2  <= r8_m6 + (64'(r8_x1p5) << 17) + (64'(w_p4) << 35);
            r9_x1b <= 64'($signed(r8_m3) >>> 8) + (64'(r8_x1p2) << 12);
            // stage 10
            r10_w    <= r9_x1b + 64'h0000_8000_0000_0000;
            r10_dvd0 <= (64'(w_pp) << 31) - r9_x2;
            // stage 11
            r11_qw <= mul_part(r10_w, $signed({1'b0, w_p1}));
            r11_qd <= mul_part(r10_dvd0, 17'sd3125);
            // stage 12
            r12_prod <= part_sum(r11_qw);
            r12_dvd  <= part_sum(r11_qd);
            // stage 13: magnitudes and signs for the divider
            r13_num       <= r12_dvd[63] ? (64'd0 - r12_dvd) : r12_dvd;
            r13_dv        <= w_div[DV_W-1] ? DV_W'(-w_div) : DV_W'(w_div);
            r13_side.temp <= r_tout_d[7];
            r13_side.dz   <= (w_div == '0);
            r13_side.neg  <= r12_dvd[63] ^ w_div[DV_W-1];
        end
    end

    // ------------------------------------------------------------------
    // Divider
    // ------------------------------------------------------------------
    logic        w_dq_vld;
    logic [63:0] w_quo;
    t_div_side   w_dq_side;

    bsc_divider u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_vf[12]),
        .i_num   (r13_num),
        .i_dv    (r13_dv),
        .i_side  (r13_side),
        .o_vld   (w_dq_vld),
        .o_quo   (w_quo),
        .o_side  (w_dq_side)
    );

    // ------------------------------------------------------------------
    // Back stages: second-order terms and pressure code
    // ------------------------------------------------------------------
    logic [63:0] r_pa, r_b_pa, r_c_pa, r_d_pa, r_e_pa;
    logic [63:0] r_b_qll, r_c_qq, r_c_y2, r_d_y2, r_e_y2, r_e_y1, r_f_s, r_g_t;
    logic [31:0] r_b_qlh;
    t_part       r_b_q8, r_d_q9;
    t_div_side   r_bs [7];   // stages A..G

    logic [63:0] w_q, w_cross;
    logic [23:0] w_t24;
    logic [15:0] w_u16, w_diff, w_code;

    assign w_q     = 64'($signed(r_pa) >>> 13);
    assign w_cross = 64'(w_q[31:0]) * 64'(w_q[63:32]);
    assign w_t24   = r_g_t[23:0] + (r_g_t[63] ? 24'd255 : 24'd0);
    assign w_u16   = w_t24[23:8];
    assign w_diff  = w_u16 - r_press_offset[15:0];
    assign w_code  = (w_diff << 2) + w_diff;

    logic [15:0] r_out_temp, r_out_code;
    logic        r_out_dz;

    // Advance the back payload
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bs[0] <= w_dq_side;
            for (int k = 1; k < 7; k++) begin
                r_bs[k] <= r_bs[k-1];
            end
            // stage A: restore the quotient sign
            r_pa <= w_dq_side.neg ? (64'd0 - w_quo) : w_quo;
            // stage B: square of the scaled quotient, P8 term partials
            r_b_qll <= 64'(w_q[31:0]) * 64'(w_q[31:0]);
            r_b_qlh <= w_cross[31:0];
            r_b_q8  <= mul_part(r_pa, 17'(w_p8));
            r_b_pa  <= r_pa;
            // stage C
            r_c_qq <= r_b_qll + {r_b_qlh[30:0], 1'b0, 32'd0};
            r_c_y2 <= part_sum(r_b_q8);
            r_c_pa <= r_b_pa;
            // stage D: P9 term partials
            r_d_q9 <= mul_part(r_c_qq, 17'(w_p9));
            r_d_y2 <= r_c_y2;
            r_d_pa <= r_c_pa;
            // stage E
            r_e_y1 <= part_sum(r_d_q9);
            r_e_y2 <= r_d_y2;
            r_e_pa <= r_d_pa;
            // stage F
            r_f_s <= r_e_pa + 64'($signed(r_e_y1) >>> 25)
                     + 64'($signed(r_e_y2) >>> 19);
            // stage G
            r_g_t <= 64'($signed(r_f_s) >>> 8) + (64'(w_p7) << 4);
            // output register: pascals, offset and scaling by five
            r_out_temp <= r_bs[6].temp;
            r_out_dz   <= r_bs[6].dz;
            r_out_code <= r_bs[6].dz ? 16'd0 : w_code;
        end
    end

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vf      <= '0;
            r_vb      <= '0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vf      <= {r_vf[11:0], i_s_tvalid};
            r_vb      <= {r_vb[5:0], w_dq_vld};
            r_out_vld <= r_vb[6];
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {r_out_code, r_out_temp};
    assign o_m_tuser  = r_out_dz;

    `BSC_ASSERT(a_dz_code_zero, o_m_tvalid && o_m_tuser |-> o_m_tdata[31:16] == 16'd0, "pressure code not zero on divide by zero")
    `BSC_ASSERT(a_stall_holds_valids, !w_en |=> $stable(r_vf) && $stable(r_vb), "valid bits moved during a stall")
    `BSC_ASSERT(a_out_hold_on_stall, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "result changed while stalled")

endmodule

FILE: hw/rtl/bsc_divider.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// bsc_divider
// Pipelined restoring divider on magnitudes: one quotient bit per stage,
// side data and valid bits travel with each transaction.
// ----------------------------------------------------------------------------
module bsc_divider
    import bsc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [QUO_W-1:0] i_num,
    input  logic [DV_W-1:0]  i_dv,
    input  t_div_side        i_side,
    output logic             o_vld,
    output logic [QUO_W-1:0] o_quo,
    output t_div_side        o_side
);

    logic [QUO_W-1:0] r_num  [DIV_STAGES];
    logic [DV_W-1:0]  r_rem  [DIV_STAGES];
    logic [DV_W-1:0]  r_dv   [DIV_STAGES];
    t_div_side        r_side [DIV_STAGES];
    logic [DIV_STAGES-1:0] r_vld;

    logic [QUO_W-1:0] n_num  [DIV_STAGES];
    logic [DV_W-1:0]  n_rem  [DIV_STAGES];
    logic [DV_W-1:0]  n_dv   [DIV_STAGES];
    t_div_side        n_side [DIV_STAGES];

    // Each stage shifts in one dividend bit and trial-subtracts the divisor
    always_comb begin
        logic [QUO_W-1:0] num_src;
        logic [DV_W-1:0]  rem_src;
        logic [DV_W:0]    trial;
        logic             ge;
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                num_src   = i_num;
                rem_src   = '0;
                n_dv[k]   = i_dv;
                n_side[k] = i_side;
            end else begin
                num_src   = r_num[k-1];
                rem_src   = r_rem[k-1];
                n_dv[k]   = r_dv[k-1];
                n_side[k] = r_side[k-1];
            end
            trial    = {rem_src, num_src[QUO_W-1]};
            ge       = (trial >= {1'b0, n_dv[k]});
            n_rem[k] = ge ? DV_W'(trial - {1'b0, n_dv[k]}) : trial[DV_W-1:0];
            n_num[k] = {num_src[QUO_W-2:0], ge};
        end
    end

    // Advance the payload when the pipeline moves
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_STAGES; k++) begin
                r_num[k]  <= n_num[k];
                r_rem[k]  <= n_rem[k];
                r_dv[k]   <= n_dv[k];
                r_side[k] <= n_side[k];
            end
        end
    end

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_STAGES-2:0], i_vld};
        end
    end

    assign o_vld  = r_vld[DIV_STAGES-1];
    assign o_quo  = r_num[DIV_STAGES-1];
    assign o_side = r_side[DIV_STAGES-1];

    `BSC_ASSERT(a_rem_below_divisor, r_vld[DIV_STAGES-1] && !r_side[DIV_STAGES-1].dz |-> r_rem[DIV_STAGES-1] < r_dv[DIV_STAGES-1], "divider remainder not below divisor")

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the barometric compensation pipeline: directed
// table of raw pairs, then randomised pairs under several coefficient sets,
// each result compared with a 64-bit integer prediction of the compensation.
// ----------------------------------------------------------------------------
module tb_top
    import bsc_pkg::*;
();

    localparam int LATENCY = 85;

    typedef struct packed {
        logic [15:0] temp;
        logic [15:0] code;
        logic        dz;
    } t_comp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_wdata = '0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [31:0] o_m_tdata;
    logic        o_m_tuser;

    // coefficient shadow copies
    logic [47:0] temp_coef;
    logic [63:0] press_lo, press_hi;
    logic [15:0] press_nine;
    logic [16:0] press_offset;

    t_comp       pending_results[$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          dz_seen = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_off_cycles = 0;

    always #5 i_clk = ~i_clk;

    baro_sensor_compensation dut (.*);

    // Arithmetic shift and truncating division on 64-bit two's complement
    function automatic logic [63:0] asr64(input logic [63:0] x, input int n);
        return $unsigned($signed(x) >>> n);
    endfunction

    function automatic logic [63:0] div_trunc(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ma, mb, q;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        q  = ma / mb;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    function automatic logic [63:0] sext16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    // Compensate one raw pair with the current coefficients
    function automatic t_comp compensate(input logic [19:0] adc_t, input logic [19:0] adc_p);
        t_comp       r;
        logic [63:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic [63:0] a, v1, d, v2, fine, tc, x1, x2, p, q, y1, y2;
        t1 = {48'd0, temp_coef[15:0]};
        t2 = sext16(temp_coef[31:16]);
        t3 = sext16(temp_coef[47:32]);
        p1 = {48'd0, press_lo[15:0]};
        p2 = sext16(press_lo[31:16]);
        p3 = sext16(press_lo[47:32]);
        p4 = sext16(press_lo[63:48]);
        p5 = sext16(press_hi[15:0]);
        p6 = sext16(press_hi[31:16]);
        p7 = sext16(press_hi[47:32]);
        p8 = sext16(press_hi[63:48]);
        p9 = sext16(press_nine);
        a    = {44'd0, adc_t >> 3} - (t1 << 1);
        v1   = asr64(a * t2, 11);
        d    = {44'd0, adc_t >> 4} - t1;
        v2   = asr64(asr64(d * d, 12) * t3, 14);
        fine = v1 + v2;
        tc   = asr64(fine * 64'd5 + 64'd128, 8);
        if ($signed(tc) < -64'sd32768)
            r.temp = 16'h8000;
        else if ($signed(tc) > 64'sd32767)
            r.temp = 16'h7FFF;
        else
            r.temp = tc[15:0];
        x1 = fine - 64'd128000;
        x2 = x1 * x1 * p6;
        x2 = x2 + ((x1 * p5) << 17);
        x2 = x2 + (p4 << 35);
        x1 = asr64(x1 * x1 * p3, 8) + ((x1 * p2) << 12);
        x1 = asr64(((64'd1 << 47) + x1) * p1, 33);
        r.code = '0;
        r.dz   = (x1 == '0);
        if (!r.dz) begin
            p  = 64'd1048576 - {44'd0, adc_p};
            p  = div_trunc(((p << 31) - x2) * 64'd3125, x1);
            q  = asr64(p, 13);
            y1 = asr64(p9 * q * q, 25);
            y2 = asr64(p8 * p, 19);
            p  = asr64(p + y1 + y2, 8) + (p7 << 4);
            p  = div_trunc(p, 64'd256);
            p  = 64'd5 * (p - {47'd0, press_offset});
            r.code = p[15:0];
        end
        return r;
    endfunction

    // Write one register while the pipeline is idle; the caller drops the enable
    task automatic write_reg(input t_cfg_index idx, input logic [63:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_TEMP_COEF:    temp_coef    = val[47:0];
            CFG_PRESS_LO:     press_lo     = val;
            CFG_PRESS_HI:     press_hi     = val;
            CFG_PRESS_NINE:   press_nine   = val[15:0];
            CFG_PRESS_OFFSET: press_offset = val[16:0];
            default: ;
        endcase
    endtask

    task automatic load_coefficients(input logic [47:0] tc, input logic [63:0] lo,
                                     input logic [63:0] hi, input logic [15:0] p9,
                                     input logic [16:0] off);
        write_reg(CFG_TEMP_COEF, {16'hDEAD, tc});
        write_reg(CFG_PRESS_LO, lo);
        write_reg(CFG_PRESS_HI, hi);
        write_reg(CFG_PRESS_NINE, {48'hBEEF_0000_0000, p9});
        write_reg(CFG_PRESS_OFFSET, {47'h1234, off});
        i_cfg_wr_en <= 1'b0;
    endtask

    // Offer one raw pair and wait for its transaction; predict on acceptance
    task automatic send_pair(input logic [19:0] adc_t, input logic [19:0] adc_p);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {adc_p, adc_t};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        pending_results.push_back(compensate(adc_t, adc_p));
    endtask

    // Drop the offer and wait for every outstanding result
    task automatic drain;
        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    // Receiver side: random stall, with an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compare each result transaction with the oldest prediction
    always @(posedge i_clk) begin
        t_comp exp_r;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen <= results_seen + 1;
            if (pending_results.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("Unexpected result %h", o_m_tdata);
            end else begin
                exp_r = pending_results.pop_front();
                if (exp_r.dz) dz_seen <= dz_seen + 1;
                if (o_m_tdata[15:0] !== exp_r.temp || o_m_tdata[31:16] !== exp_r.code ||
                    o_m_tuser !== exp_r.dz) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("Mismatch: exp temp %h code %h dz %b, got %h %h %b",
                                 exp_r.temp, exp_r.code, exp_r.dz,
                                 o_m_tdata[15:0], o_m_tdata[31:16], o_m_tuser);
                end
            end
        end
    end

    // Directed table; typed rows apply with all coefficients zero
    typedef struct {
        logic [19:0] adc_t;
        logic [19:0] adc_p;
        logic        typed;
        t_comp       result;
    } t_row;

    t_row directed_rows[] = '{
        '{20'h00000, 20'h00000, 1'b1, '{16'h0000, 16'h0000, 1'b1}},
        '{20'hFFFFF, 20'hFFFFF, 1'b1, '{16'h0000, 16'h0000, 1'b1}},
        '{20'h80000, 20'h00001, 1'b0, '0},
        '{20'h7FFFF, 20'h80000, 1'b0, '0},
        '{20'hFFFFF, 20'h00000, 1'b0, '0},
        '{20'h00000, 20'hFFFFF, 1'b0, '0},
        '{20'h55555, 20'hAAAAA, 1'b0, '0},
        '{20'hAAAAA, 20'h55555, 1'b0, '0},
        '{20'h7E000, 20'h51000, 1'b0, '0},
        '{20'h00010, 20'h00010, 1'b0, '0}
    };

    // One random phase of raw pairs
    task automatic random_pairs(input int count);
        for (int k = 0; k < count; k++)
            send_pair(20'($urandom_range(20'hFFFFF)), 20'($urandom_range(20'hFFFFF)));
    endtask

    // Realistic pair near typical readings, plus some full-range noise
    task automatic random_realistic(input int count);
        for (int k = 0; k < count; k++)
            if ($urandom_range(9) < 8)
                send_pair(20'(20'h7E000 + $urandom_range(20'h3FFF) - 20'h2000),
                          20'(20'h50000 + $urandom_range(20'hFFFF) - 20'h8000));
            else
                send_pair(20'($urandom_range(20'hFFFFF)), 20'($urandom_range(20'hFFFFF)));
    endtask

    initial begin
        temp_coef = '0; press_lo = '0; press_hi = '0; press_nine = '0; press_offset = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows under reset coefficients (all divisors zero)
        foreach (directed_rows[r]) begin
            send_pair(directed_rows[r].adc_t, directed_rows[r].adc_p);
            if (directed_rows[r].typed) begin
                void'(pending_results.pop_back());
                pending_results.push_back(directed_rows[r].result);
            end
        end
        drain();

        // Typical factory coefficients, then directed rows again
        load_coefficients({16'hFC18, 16'h6738, 16'd27504},
                          {16'd2855, 16'hEC2A, 16'hD0B6, 16'd36477},
                          {16'hFFF9, 16'h3D74, 16'hFFBA, 16'd140},
                          16'd6000, 17'd90000);
        foreach (directed_rows[r]) send_pair(directed_rows[r].adc_t, directed_rows[r].adc_p);
        drain();

        // Phases with different idling
        send_idle_pct = 0;  recv_stall_pct = 0;  random_realistic(400);
        send_idle_pct = 49; recv_stall_pct = 0;  random_realistic(300);
        drain();

        // Long receiver hold-off while the sender keeps offering
        hold_off_cycles = 300;
        send_idle_pct = 0; random_realistic(200);
        drain();

        send_idle_pct = 0;  recv_stall_pct = 49; random_realistic(300);
        send_idle_pct = 15; recv_stall_pct = 15; random_pairs(200);
        drain();

        // Extreme coefficient sets, then a random set
        load_coefficients({16'h8000, 16'h7FFF, 16'hFFFF},
                          {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF},
                          {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000},
                          16'h7FFF, 17'h1FFFF);
        random_pairs(200);
        drain();
        load_coefficients({16'h7FFF, 16'h8000, 16'h7FFF},
                          {16'hFFFF, 16'h8000, 16'h7FFF, 16'h8000},
                          {16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF},
                          16'h8000, 17'd0);
        recv_stall_pct = 0; send_idle_pct = 0;
        random_pairs(200);
        drain();
        load_coefficients(48'({$urandom, $urandom}),
                          {$urandom, $urandom}, {$urandom, $urandom},
                          16'($urandom_range(16'hFFFF)), 17'($urandom_range(17'h1FFFF)));
        recv_stall_pct = 49; send_idle_pct = 49;
        random_pairs(200);
        drain();

        $display("Checked %0d results over five coefficient sets, %0d with zero divisor.",
                 results_seen, dz_seen);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Timeout guard
    initial begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end
endmodule
